>>> hw/rtl/b2c_pkg.sv
// Package for the bitplane-to-chunky converter with frame hash.
// Shared types, register indexes, limits and the plane spread function.
// No dependencies.
package b2c_pkg;

  localparam int unsigned NUM_PLANES  = 4;
  localparam int unsigned PIX_PER_WORD = 8;

  localparam logic [8:0]  MAX_LINE_PIXELS = 9'd320;
  localparam logic [7:0]  MAX_LINES       = 8'd200;
  localparam logic [31:0] HASH_POLY       = 32'h0000_008d;

  localparam logic [8:0]  PIXEL_COUNT_RST = 9'd320;
  localparam logic [2:0]  FINE_SKIP_RST   = 3'd0;
  localparam logic [7:0]  LINE_COUNT_RST  = 8'd200;

  typedef enum logic [1:0] {
    CFG_PIXEL_COUNT = 2'd0,
    CFG_FINE_SKIP   = 2'd1,
    CFG_LINE_COUNT  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [8:0] pixel_count;
    logic [2:0] fine_skip;
    logic [7:0] line_count;
  } cfg_t;

  // one converted result
  typedef struct packed {
    logic [31:0] hash;
    logic        eof;
    logic        eol;
    logic [31:0] word;
  } result_t;

  // plane byte -> bit k of each nibble, MSB is pixel 0
  function automatic logic [31:0] spread_plane(input logic [7:0] plane_byte,
                                               input logic [1:0] plane);
    logic [31:0] w;
    w = '0;
    for (int p = 0; p < PIX_PER_WORD; p++) begin
      w[4*p + int'(plane)] = plane_byte[7-p];
    end
    return w;
  endfunction

endpackage

>>> hw/rtl/b2c_shuffle.sv
// Planar-to-chunky bit shuffle and fine-skip funnel shift.
// Combinational; uses b2c_pkg.
module b2c_shuffle (
  input  logic [31:0] planes,      // plane0 [7:0] .. plane3 [31:24]
  input  logic [31:0] held_word,
  input  logic [2:0]  fine_skip,
  output logic [31:0] chunky_new,  // unshifted word of this transaction
  output logic [31:0] chunky_out   // funnel-shifted word
);
  import b2c_pkg::*;

  logic [63:0] funnel;
  logic [5:0]  shift_amt;

  always_comb begin
    chunky_new = '0;
    for (int k = 0; k < NUM_PLANES; k++) begin
      chunky_new = chunky_new | spread_plane(planes[8*k +: 8], 2'(k));
    end
  end

  assign shift_amt = {1'b0, fine_skip, 2'b00};
  assign funnel    = {chunky_new, held_word} >> shift_amt;
  assign chunky_out = (fine_skip != 3'd0) ? funnel[31:0] : chunky_new;

endmodule

>>> hw/rtl/b2c_track.sv
// Line/frame tracking, last-word masking and running hash.
// Holds the converter state; uses b2c_pkg.
module b2c_track (
  input  logic              clk,
  input  logic              rst_n,
  input  b2c_pkg::cfg_t     cfg,
  input  logic              fire,        // stage-1 transaction consumed
  input  logic [31:0]       chunky_new,
  input  logic [31:0]       chunky_out,
  output logic [31:0]       held_word,
  output logic              prime,       // current transaction only primes
  output b2c_pkg::result_t  res
);
  import b2c_pkg::*;

  logic [31:0] hash_r,  hash_nxt;
  logic [31:0] held_r,  held_nxt;
  logic [5:0]  words_r, words_nxt;
  logic [7:0]  lines_r, lines_nxt;
  logic        primed_r, primed_nxt;

  logic [8:0]  pix_eff;
  logic [7:0]  lines_eff;
  logic [8:0]  pix_p7;
  logic [5:0]  words_per_line;
  logic [31:0] mask;
  logic [31:0] hash_step;

  always_comb begin
    pix_eff = cfg.pixel_count;
    if (cfg.pixel_count == 9'd0) pix_eff = 9'd1;
    else if (cfg.pixel_count > MAX_LINE_PIXELS) pix_eff = MAX_LINE_PIXELS;
    lines_eff = cfg.line_count;
    if (cfg.line_count == 8'd0) lines_eff = 8'd1;
    else if (cfg.line_count > MAX_LINES) lines_eff = MAX_LINES;
  end

  assign pix_p7         = pix_eff + 9'd7;
  assign words_per_line = pix_p7[8:3];

  always_comb begin
    mask = '1;
    if (pix_eff[2:0] != 3'd0) begin
      for (int p = 0; p < PIX_PER_WORD; p++) begin
        mask[4*p +: 4] = (3'(p) < pix_eff[2:0]) ? 4'hf : 4'h0;
      end
    end
  end

  assign prime     = (cfg.fine_skip != 3'd0) && !primed_r;
  assign held_word = held_r;

  always_comb begin
    res.eol  = ({1'b0, words_r} + 7'd1) >= {1'b0, words_per_line};
    res.eof  = res.eol && (({1'b0, lines_r} + 9'd1) >= {1'b0, lines_eff});
    res.word = res.eol ? (chunky_out & mask) : chunky_out;
    hash_step = {hash_r[30:0], 1'b0} ^ (hash_r[31] ? HASH_POLY : 32'd0);
    res.hash = hash_step ^ res.word;
  end

  always_comb begin
    hash_nxt   = hash_r;
    held_nxt   = held_r;
    words_nxt  = words_r;
    lines_nxt  = lines_r;
    primed_nxt = primed_r;
    if (fire) begin
      held_nxt = chunky_new;
      if (prime) begin
        primed_nxt = 1'b1;
      end else if (res.eol) begin
        words_nxt  = '0;
        primed_nxt = 1'b0;
        if (res.eof) begin
          lines_nxt = '0;
          hash_nxt  = '0;
        end else begin
          lines_nxt = lines_r + 8'd1;
          hash_nxt  = res.hash;
        end
      end else begin
        words_nxt = words_r + 6'd1;
        hash_nxt  = res.hash;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= '0;
      held_r   <= '0;
      words_r  <= '0;
      lines_r  <= '0;
      primed_r <= 1'b0;
    end else begin
      hash_r   <= hash_nxt;
      held_r   <= held_nxt;
      words_r  <= words_nxt;
      lines_r  <= lines_nxt;
      primed_r <= primed_nxt;
    end
  end

endmodule

>>> hw/rtl/bitplane_to_chunky_with_hash.sv
// Top level of the bitplane-to-chunky converter with running frame hash.
// Uses b2c_pkg, b2c_shuffle and b2c_track.
//
// Each input transaction carries one byte from each of four bitplanes (eight
// pixels) and yields one 32-bit chunky word, pixel 0 in the lowest nibble,
// plane k in bit k of each nibble. With a nonzero fine_skip the first
// transaction of a line only primes the held word and produces no output;
// later words are funnel-shifted by fine_skip pixels. The last word of a line
// is masked to pixel_count and flagged with out_tlast; the last word of the
// last line also carries out_tuser, after which the hash restarts at zero.
// Timing: an input register feeds the shuffle/track logic, whose result is
// captured in the output register that drives out_tvalid. One transaction
// per cycle is sustained while out_tready stays high. Configuration is
// written through cfg_we/cfg_index/cfg_data and must only change while no
// transaction is in flight.
module bitplane_to_chunky_with_hash (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // plane0_byte, plane1_byte, plane2_byte, plane3_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // chunky_word, frame_hash
  output logic        out_tlast,  // end_of_line
  output logic        out_tuser   // end_of_frame
);
  import b2c_pkg::*;

  cfg_t        cfg_r, cfg_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_data_r;
  logic        s1_fire;

  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r;

  logic [31:0] chunky_new;
  logic [31:0] chunky_out;
  logic [31:0] held_word;
  logic        prime;
  result_t     res;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_PIXEL_COUNT: cfg_nxt.pixel_count = cfg_data;
        CFG_FINE_SKIP:   cfg_nxt.fine_skip   = cfg_data[2:0];
        CFG_LINE_COUNT:  cfg_nxt.line_count  = cfg_data[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_count <= PIXEL_COUNT_RST;
      cfg_r.fine_skip   <= FINE_SKIP_RST;
      cfg_r.line_count  <= LINE_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stage 1 consumes its transaction when it only primes, or when the output
  // register is empty or being drained this cycle
  assign s1_fire   = s1_valid_r && (prime || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) s1_valid_nxt = 1'b1;
    else if (s1_fire)           s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) s1_data_r <= in_tdata;
  end

  b2c_shuffle u_shuffle (
    .planes     (s1_data_r),
    .held_word  (held_word),
    .fine_skip  (cfg_r.fine_skip),
    .chunky_new (chunky_new),
    .chunky_out (chunky_out)
  );

  b2c_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fire       (s1_fire),
    .chunky_new (chunky_new),
    .chunky_out (chunky_out),
    .held_word  (held_word),
    .prime      (prime),
    .res        (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && !prime) out_valid_nxt = 1'b1;
    else if (out_tready)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !prime) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.hash, out_res_r.word};
  assign out_tlast  = out_res_r.eol;
  assign out_tuser  = out_res_r.eof;

`ifndef SYNTHESIS
  // end of frame only ever comes with end of line
  a_eof_has_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser || out_tlast))
    else $error("end_of_frame without end_of_line");

  // an emitting transaction always lands in the output register
  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !prime) |=> out_valid_r)
    else $error("emitted result lost");

  // full pipe with stalled output must back-pressure the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !prime && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline stalled");
`endif

endmodule

>>> dv/bitplane_to_chunky_with_hash_tb.sv
// Self-checking testbench for the bitplane-to-chunky converter with frame hash.
// A directed stimulus table, then randomized line/frame phases, checked against
// a local predictor or hand-written expectations. Depends on b2c_pkg and bitplane_to_chunky_with_hash.
module bitplane_to_chunky_with_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b2c_pkg::*;

  localparam int unsigned ITEM_TARGET = 1600;
  // last stretch of the run goes without any idling on either side
  localparam int unsigned CALM_FROM   = ITEM_TARGET - 200;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PLAN_LEN    = 40;

  // one row of the directed table: either a register write or an input item
  typedef struct packed {
    logic        is_cfg;
    cfg_index_t  idx;
    logic [8:0]  val;
    logic [7:0]  p0;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [7:0]  p3;
    logic        typed;   // want holds a hand-written expectation
    result_t     want;
  } plan_row_t;

  localparam result_t NO_WANT = '0;

  // result_t pattern order: hash, eof, eol, word
  localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
    // reset settings: 320 pixels, no skip, 200 lines
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1,
      '{32'hffff_ffff, 1'b0, 1'b0, 32'hffff_ffff}},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
      '{32'hffff_ff73, 1'b0, 1'b0, 32'h0000_0000}},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h00, 8'h01, 8'h00, 8'haa, 1'b0, NO_WANT},
    // shrink line mid-line: next word closes line and frame
    '{1'b1, CFG_PIXEL_COUNT, 9'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CFG_LINE_COUNT,  9'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1,
      '{32'h0000_000f, 1'b1, 1'b1, 32'h0000_000f}},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000}},
    // zero pixel count acts as one pixel
    '{1'b1, CFG_PIXEL_COUNT, 9'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1,
      '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001}},
    // maximum skip, one word per line, two lines
    '{1'b1, CFG_PIXEL_COUNT, 9'd8, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CFG_LINE_COUNT,  9'd2, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CFG_FINE_SKIP,   9'd7, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h9a, 8'hbc, 8'hde, 8'hf0, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h0f, 8'hf0, 8'h3c, 8'hc3, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h5a, 8'ha5, 8'h69, 8'h96, 1'b0, NO_WANT},
    // prime, then drop skip to zero: primed flag must be ignored
    '{1'b1, CFG_FINE_SKIP,   9'd4, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h55, 8'haa, 8'h55, 8'haa, 1'b0, NO_WANT},
    '{1'b1, CFG_FINE_SKIP,   9'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h01, 8'h02, 8'h04, 8'h08, 1'b0, NO_WANT},
    // counts above the maximum saturate
    '{1'b1, CFG_PIXEL_COUNT, 9'h1ff, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CFG_LINE_COUNT,  9'h0ff, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h7f, 8'h80, 8'hfe, 8'h01, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h80, 8'h7f, 8'h01, 8'hfe, 1'b0, NO_WANT},
    // back to reset sizes, skip 1 with junk in the unused data bits
    '{1'b1, CFG_PIXEL_COUNT, 9'd320, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CFG_FINE_SKIP,   9'h1f9, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CFG_LINE_COUNT,  9'd200, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'hc0, 8'h30, 8'h0c, 8'h03, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'hff, 8'h00, 8'hff, 8'h00, 1'b0, NO_WANT},
    // shrink while primed so the next word ends the line, then short frame
    '{1'b1, CFG_PIXEL_COUNT, 9'd13, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CFG_FINE_SKIP,   9'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b1, CFG_LINE_COUNT,  9'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h11, 8'h22, 8'h44, 8'h88, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'he7, 8'h18, 8'hdb, 8'h24, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h3a, 8'hc5, 8'h96, 8'h69, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'hfe, 8'hef, 8'h7b, 8'hb7, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'h08, 8'h10, 8'h20, 8'h40, 1'b0, NO_WANT},
    '{1'b0, CFG_PIXEL_COUNT, 9'd0, 8'hd2, 8'h2d, 8'hf1, 8'h1f, 1'b0, NO_WANT}
  };

  // DUT signals; every input starts at a known value
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [8:0]  cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  // predictor copy of registers and state, reset values
  logic [8:0]  px_count_q  = PIXEL_COUNT_RST;
  logic [2:0]  skip_q      = FINE_SKIP_RST;
  logic [7:0]  ln_count_q  = LINE_COUNT_RST;
  logic [31:0] hash_q      = '0;
  logic [31:0] held_q      = '0;
  int unsigned words_in_line = 0;
  int unsigned lines_in_frame = 0;
  logic        primed_q    = 1'b0;

  result_t     pending_results[$];
  result_t     head_result;
  int unsigned err_count  = 0;
  int unsigned shown      = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  bit          calm       = 1'b0;

  bitplane_to_chunky_with_hash i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // plane0_byte, plane1_byte, plane2_byte, plane3_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // chunky_word, frame_hash
    .out_tlast  (out_tlast),  // end_of_line
    .out_tuser  (out_tuser)   // end_of_frame
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor: plane bytes in, chunky word out. Returns 0 for a priming item.
  function automatic bit convert_planes(input logic [31:0] planes, output result_t res);
    logic [31:0] n;
    logic [31:0] word;
    int unsigned pix;
    int unsigned lines;
    int unsigned words;
    begin
      res = '0;
      n = '0;
      for (int p = 0; p < 8; p++) begin
        for (int k = 0; k < 4; k++) begin
          n[4*p + k] = planes[8*k + 7 - p];
        end
      end
      // first item of a skipped line only loads the held word
      if (skip_q != 3'd0 && !primed_q) begin
        held_q   = n;
        primed_q = 1'b1;
        return 1'b0;
      end
      if (skip_q != 3'd0) begin
        word = (held_q >> (4 * skip_q)) | (n << (32 - 4 * skip_q));
      end else begin
        word = n;   // primed flag irrelevant without skip
      end
      held_q = n;

      pix = px_count_q;
      if (pix < 1) pix = 1;
      if (pix > MAX_LINE_PIXELS) pix = MAX_LINE_PIXELS;
      lines = ln_count_q;
      if (lines < 1) lines = 1;
      if (lines > MAX_LINES) lines = MAX_LINES;
      words = (pix + 7) >> 3;

      if (words_in_line + 1 >= words) begin
        res.eol = 1'b1;
        if (pix % 8 != 0) word &= (32'h1 << (4 * (pix % 8))) - 32'h1;
      end

      hash_q = hash_q[31] ? ((hash_q << 1) ^ HASH_POLY) : (hash_q << 1);
      hash_q ^= word;
      res.word = word;
      res.hash = hash_q;

      if (res.eol) begin
        words_in_line = 0;
        primed_q      = 1'b0;
        if (lines_in_frame + 1 >= lines) begin
          res.eof        = 1'b1;
          lines_in_frame = 0;
          hash_q         = '0;
        end else begin
          lines_in_frame++;
        end
      end else begin
        words_in_line++;
      end
      return 1'b1;
    end
  endfunction

  // Register write; called at a falling edge, returns at a falling edge.
  task automatic write_reg(input cfg_index_t idx, input logic [8:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_PIXEL_COUNT: px_count_q = val;
      CFG_FINE_SKIP:   skip_q     = val[2:0];
      CFG_LINE_COUNT:  ln_count_q = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One input transaction, with an optional idle burst in front.
  task automatic send_planes(input logic [31:0] planes, input bit typed,
                             input result_t want);
    result_t pred;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= planes;
    do @(posedge clk); while (!in_tready);
    if (convert_planes(planes, pred)) pending_results.push_back(typed ? want : pred);
    sent_count++;
    @(negedge clk);
  endtask

  // Wait for all outstanding results plus the pipeline depth, since a
  // priming item may still be in flight with nothing expected.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random stall bursts, none in the final stretch
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (shown < 10) begin
          $display("unexpected result: word=%h hash=%h eol=%b eof=%b",
                   out_tdata[31:0], out_tdata[63:32], out_tlast, out_tuser);
          shown++;
        end
      end else begin
        head_result = pending_results.pop_front();
        if (out_tdata[31:0] !== head_result.word || out_tdata[63:32] !== head_result.hash ||
            out_tlast !== head_result.eol || out_tuser !== head_result.eof) begin
          err_count++;
          if (shown < 10) begin
            $display("mismatch: exp word=%h hash=%h eol=%b eof=%b",
                     head_result.word, head_result.hash, head_result.eol, head_result.eof);
            $display("          got word=%h hash=%h eol=%b eof=%b",
                     out_tdata[31:0], out_tdata[63:32], out_tlast, out_tuser);
            shown++;
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned mode;
    int unsigned pix;
    int unsigned lines;
    int unsigned words;
    int unsigned frame_len;
    int unsigned n_items;
    int unsigned fine;
    logic [8:0]  px_val;
    logic [8:0]  ln_val;
    logic [31:0] planes;
    bit          was_item;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table; drain before a register write that follows an item
    was_item = 1'b0;
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (PLAN[r].is_cfg) begin
        if (was_item) settle();
        write_reg(PLAN[r].idx, PLAN[r].val);
        was_item = 1'b0;
      end else begin
        send_planes({PLAN[r].p3, PLAN[r].p2, PLAN[r].p1, PLAN[r].p0},
                    PLAN[r].typed, PLAN[r].want);
        was_item = 1'b1;
      end
    end

    // random phases: new sizes, then about a frame or so of items
    while (sent_count < ITEM_TARGET) begin
      settle();
      mode = $urandom_range(0, 11);
      fine = $urandom_range(0, 7);
      if (mode == 0) begin
        // pixel count extremes, few lines
        case ($urandom_range(0, 3))
          0: px_val = 9'd0;
          1: px_val = 9'd320;
          2: px_val = 9'($urandom_range(321, 511));
          default: px_val = 9'd1;
        endcase
        ln_val = 9'($urandom_range(1, 3));
      end else if (mode == 1) begin
        // line count extremes, one word per line
        case ($urandom_range(0, 2))
          0: ln_val = 9'd0;
          1: ln_val = 9'd200;
          default: ln_val = 9'($urandom_range(201, 255));
        endcase
        px_val = 9'($urandom_range(1, 8));
      end else begin
        px_val = 9'($urandom_range(1, 40));
        ln_val = 9'($urandom_range(1, 5));
      end
      // junk in the data bits above the skip and line count registers' widths
      ln_val[8] = 1'($urandom);
      write_reg(CFG_PIXEL_COUNT, px_val);
      write_reg(CFG_FINE_SKIP, {6'($urandom), 3'(fine)});
      write_reg(CFG_LINE_COUNT, ln_val);

      pix = px_val;
      if (pix < 1) pix = 1;
      if (pix > MAX_LINE_PIXELS) pix = MAX_LINE_PIXELS;
      lines = ln_val[7:0];
      if (lines < 1) lines = 1;
      if (lines > MAX_LINES) lines = MAX_LINES;
      words = (pix + 7) >> 3;
      frame_len = lines * (words + ((fine != 0) ? 1 : 0));
      n_items = frame_len + $urandom_range(0, frame_len / 2 + 2);
      if (n_items > 600) n_items = 600;

      for (int i = 0; i < n_items; i++) begin
        calm = (sent_count >= CALM_FROM);
        case ($urandom_range(0, 9))
          0: planes = 32'h0000_0000;
          1: planes = 32'hffff_ffff;
          default: planes = $urandom;
        endcase
        send_planes(planes, 1'b0, NO_WANT);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/b2c_pkg.sv
hw/rtl/b2c_shuffle.sv
hw/rtl/b2c_track.sv
hw/rtl/bitplane_to_chunky_with_hash.sv
dv/bitplane_to_chunky_with_hash_tb.sv
